[design/three_wire_rtc_serial_master_top_defines.svh]
// Assertion macros for the three-wire RTC serial master.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_TOP_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTC3W_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtc3w assertion failed");

// Next-cycle implication, disabled during reset.
`define RTC3W_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtc3w assertion failed");

`endif

[design/rtc3w_pkg.sv]
`default_nettype none
package rtc3w_pkg;

	localparam int DATA_BITS = 8;
	localparam int CMD_BITS  = 8;
	localparam int CNT_W     = 5;
	localparam logic [CNT_W-1:0] CMD_CNT   = CNT_W'(CMD_BITS);
	localparam logic [CNT_W-1:0] TOTAL_CNT = CNT_W'(CMD_BITS + DATA_BITS);

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_GUARD       = 2'd1;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
	localparam logic [7:0] GUARD_RST       = 8'd4;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] command_byte;
		logic [7:0] write_data;
		logic       io_sample;
	} in_item_t;

	typedef struct packed {
		logic       enable_level;
		logic       clock_level;
		logic       data_level;
		logic [7:0] read_byte;
		logic       read_done;
		logic       busy_res;
		logic       rejected;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic        is_req;
		logic        is_rd;
		logic [15:0] send_word;
		logic        io_sample;
	} cmd_t;

	function automatic logic [7:0] lim(input logic [7:0] r);
		return (r == 8'd0) ? 8'd1 : r;
	endfunction

endpackage
`default_nettype wire

[design/three_wire_rtc_serial_master_top.sv]
`default_nettype none
// Three-wire RTC serial master: every input item is one time tick of the
// sequencer and yields exactly one result item with the pin levels after
// that tick. One item is accepted per clock cycle while the two-entry queue
// behind the classifier has room; an accepted item is registered in that
// queue and then in the sequencer's output register, where its result is
// presented. Throughput is set by the sequencer, which advances one tick
// per cycle while its output register is empty or being taken. Configuration
// writes are always ready and take effect on the next cycle.
`include "three_wire_rtc_serial_master_top_defines.svh"
module three_wire_rtc_serial_master_top (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire rtc3w_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire                       out_ready,
	output rtc3w_pkg::out_item_t      out_item,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire [1:0]                 cfg_index,
	input  wire [7:0]                 cfg_data
);

	rtc3w_pkg::cmd_t front_cmd;
	rtc3w_pkg::cmd_t back_cmd;
	logic            back_valid;
	logic            back_ready;

	assign cfg_ready = 1'b1;

	rtc3w_front u_front (
		.in_item (in_item),
		.cmd     (front_cmd)
	);

	rtc3w_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_cmd)
	);

	rtc3w_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	`RTC3W_ASSERT_IMP(a_done_not_busy, out_valid && out_item.read_done, !out_item.busy_res)
	`RTC3W_ASSERT_IMP(a_clk_low_when_disabled, out_valid && !out_item.enable_level,
		!out_item.clock_level)
	`RTC3W_ASSERT_IMP(a_byte_zero_unless_done, out_valid && !out_item.read_done,
		out_item.read_byte == 8'd0)
	`RTC3W_ASSERT_NXT(a_queue_drains, !in_ready && out_ready, in_ready)

endmodule
`default_nettype wire

[design/rtc3w_front.sv]
`default_nettype none
module rtc3w_front (
	input  wire rtc3w_pkg::in_item_t in_item,
	output rtc3w_pkg::cmd_t          cmd
);

	always_comb begin
		cmd.is_req    = (in_item.func == rtc3w_pkg::FUNC_WRITE) ||
		                (in_item.func == rtc3w_pkg::FUNC_READ);
		cmd.is_rd     = (in_item.func == rtc3w_pkg::FUNC_READ);
		cmd.io_sample = in_item.io_sample;
		if (cmd.is_rd) begin
			cmd.send_word = {8'h00, in_item.command_byte | 8'h01};
		end else begin
			cmd.send_word = {in_item.write_data, in_item.command_byte & 8'hFE};
		end
	end

endmodule
`default_nettype wire

[design/rtc3w_queue.sv]
`default_nettype none
module rtc3w_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  wire rtc3w_pkg::cmd_t push_data,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output rtc3w_pkg::cmd_t      pop_data
);

	rtc3w_pkg::cmd_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[design/rtc3w_back.sv]
`default_nettype none
module rtc3w_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	input  wire [1:0]            cfg_index,
	input  wire [7:0]            cfg_data,
	input  wire                  cmd_valid,
	output logic                 cmd_ready,
	input  wire rtc3w_pkg::cmd_t cmd,
	output logic                 out_valid,
	input  wire                  out_ready,
	output rtc3w_pkg::out_item_t out_item
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_LOW   = 3'd2,
		PH_HIGH  = 3'd3,
		PH_HOLD  = 3'd4
	} phase_t;

	phase_t                          phase_q, phase_d;
	logic [rtc3w_pkg::CNT_W-1:0]     bit_count_q, bit_count_d, bc_inc;
	logic [15:0]                     send_q, send_d;
	logic [7:0]                      recv_q, recv_d;
	logic [7:0]                      tick_q, tick_d, nxt;
	logic                            is_read_q, is_read_d;
	logic                            en_q, en_d, clk_q, clk_d, dat_q, dat_d;
	logic [7:0]                      half_q, guard_q, half_lim, guard_lim;
	logic                            rej, done;
	logic [7:0]                      rbyte;
	logic                            step;
	rtc3w_pkg::out_item_t            out_q;
	logic                            out_valid_q;

	assign cmd_ready = !out_valid_q || out_ready;
	assign step      = cmd_valid && cmd_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign half_lim  = rtc3w_pkg::lim(half_q);
	assign guard_lim = rtc3w_pkg::lim(guard_q);
	assign nxt       = tick_q + 8'd1;
	assign bc_inc    = bit_count_q + 5'd1;

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		send_d      = send_q;
		recv_d      = recv_q;
		tick_d      = tick_q;
		is_read_d   = is_read_q;
		en_d        = en_q;
		clk_d       = clk_q;
		dat_d       = dat_q;
		rej         = 1'b0;
		done        = 1'b0;
		rbyte       = 8'd0;
		if (phase_q == PH_IDLE) begin
			if (cmd.is_req) begin
				is_read_d   = cmd.is_rd;
				send_d      = cmd.send_word;
				recv_d      = 8'd0;
				bit_count_d = '0;
				tick_d      = 8'd0;
				en_d        = 1'b1;
				clk_d       = 1'b0;
				dat_d       = 1'b1;
				phase_d     = PH_SETUP;
			end
		end else begin
			rej = cmd.is_req;
			unique case (phase_q)
				PH_SETUP: begin
					if (nxt >= guard_lim) begin
						tick_d      = 8'd0;
						bit_count_d = '0;
						dat_d       = send_q[0];
						phase_d     = PH_LOW;
					end else begin
						tick_d = nxt;
					end
				end
				PH_LOW: begin
					if (nxt >= half_lim) begin
						if (is_read_q && bit_count_q >= rtc3w_pkg::CMD_CNT && cmd.io_sample) begin
							recv_d[bit_count_q[2:0]] = 1'b1;
						end
						tick_d  = 8'd0;
						clk_d   = 1'b1;
						phase_d = PH_HIGH;
					end else begin
						tick_d = nxt;
					end
				end
				PH_HIGH: begin
					if (nxt >= half_lim) begin
						tick_d      = 8'd0;
						clk_d       = 1'b0;
						bit_count_d = bc_inc;
						if (bc_inc >= rtc3w_pkg::TOTAL_CNT) begin
							en_d    = 1'b0;
							dat_d   = 1'b1;
							phase_d = PH_HOLD;
						end else begin
							dat_d   = (is_read_q && bc_inc >= rtc3w_pkg::CMD_CNT) ? 1'b1
							          : send_q[bc_inc[3:0]];
							phase_d = PH_LOW;
						end
					end else begin
						tick_d = nxt;
					end
				end
				PH_HOLD: begin
					if (nxt >= guard_lim) begin
						tick_d  = 8'd0;
						done    = is_read_q;
						rbyte   = is_read_q ? recv_q : 8'd0;
						phase_d = PH_IDLE;
					end else begin
						tick_d = nxt;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					tick_d  = 8'd0;
					en_d    = 1'b0;
					clk_d   = 1'b0;
					dat_d   = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			send_q      <= 16'd0;
			recv_q      <= 8'd0;
			tick_q      <= 8'd0;
			is_read_q   <= 1'b0;
			en_q        <= 1'b0;
			clk_q       <= 1'b0;
			dat_q       <= 1'b1;
			half_q      <= rtc3w_pkg::HALF_PERIOD_RST;
			guard_q     <= rtc3w_pkg::GUARD_RST;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == rtc3w_pkg::CFG_HALF_PERIOD) begin
					half_q <= cfg_data;
				end
				if (cfg_index == rtc3w_pkg::CFG_GUARD) begin
					guard_q <= cfg_data;
				end
			end
			if (step) begin
				phase_q     <= phase_d;
				bit_count_q <= bit_count_d;
				send_q      <= send_d;
				recv_q      <= recv_d;
				tick_q      <= tick_d;
				is_read_q   <= is_read_d;
				en_q        <= en_d;
				clk_q       <= clk_d;
				dat_q       <= dat_d;
				out_q.enable_level <= en_d;
				out_q.clock_level  <= clk_d;
				out_q.data_level   <= dat_d;
				out_q.read_byte    <= rbyte;
				out_q.read_done    <= done;
				out_q.busy_res     <= (phase_d != PH_IDLE);
				out_q.rejected     <= rej;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYC = 300;
	localparam int NUM_SETS = 10;
	localparam int ITEMS_PER_SET = 150;

	localparam rtc3w_pkg::out_item_t OUT_IDLE = '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0};
	localparam rtc3w_pkg::out_item_t OUT_START = '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0};
	localparam rtc3w_pkg::out_item_t OUT_START_REJ =
		'{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1};
	localparam rtc3w_pkg::out_item_t OUT_RD_FF = '{1'b0, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b0};

	localparam logic [7:0] HALF_SET [NUM_SETS] = '{8'd0, 8'd1, 8'd2, 8'd1, 8'd3,
		8'd0, 8'd0, 8'd10, 8'd1, 8'd0};
	localparam logic [7:0] GUARD_SET [NUM_SETS] = '{8'd0, 8'd1, 8'd1, 8'd3, 8'd2,
		8'd0, 8'd0, 8'd10, 8'd255, 8'd0};

	typedef enum logic [2:0] {P_IDLE, P_GUARD_ON, P_LOW, P_HIGH, P_GUARD_OFF} seq_phase_t;

	typedef struct packed {
		rtc3w_pkg::in_item_t  item;
		logic [5:0]           reps;
		logic                 typed;
		rtc3w_pkg::out_item_t want;
	} dir_row_t;

	// reset config: half period 1, guard 4 -> a transfer ends 40 ticks after its start
	localparam dir_row_t DIR_ROWS [12] = '{
		'{'{rtc3w_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0}, 6'd1, 1'b1, OUT_IDLE},
		'{'{FUNC_NOP, 8'hFF, 8'hFF, 1'b1}, 6'd1, 1'b1, OUT_IDLE},
		'{'{rtc3w_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 1'b1}, 6'd1, 1'b1, OUT_START},
		'{'{rtc3w_pkg::FUNC_READ, 8'h00, 8'h00, 1'b0}, 6'd1, 1'b1, OUT_START_REJ},
		'{'{rtc3w_pkg::FUNC_WRITE, 8'hAA, 8'h55, 1'b1}, 6'd1, 1'b1, OUT_START_REJ},
		'{'{FUNC_NOP, 8'h00, 8'h00, 1'b0}, 6'd1, 1'b0, OUT_IDLE},
		'{'{rtc3w_pkg::FUNC_TICK, 8'h5A, 8'hA5, 1'b0}, 6'd37, 1'b0, OUT_IDLE},
		'{'{rtc3w_pkg::FUNC_READ, 8'h00, 8'hFF, 1'b0}, 6'd1, 1'b1, OUT_START},
		'{'{rtc3w_pkg::FUNC_READ, 8'hFF, 8'h00, 1'b1}, 6'd1, 1'b1, OUT_START_REJ},
		'{'{rtc3w_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b1}, 6'd38, 1'b0, OUT_IDLE},
		'{'{rtc3w_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b1}, 6'd1, 1'b1, OUT_RD_FF},
		'{'{rtc3w_pkg::FUNC_TICK, 8'h00, 8'h00, 1'b0}, 6'd1, 1'b1, OUT_IDLE}
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	rtc3w_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	rtc3w_pkg::out_item_t out_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	three_wire_rtc_serial_master_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// sequencer model state
	seq_phase_t m_phase;
	logic [4:0] m_bits;
	logic [15:0] m_send;
	logic [7:0] m_recv;
	logic [7:0] m_tick;
	logic m_read;
	logic m_en, m_clk, m_dat;
	logic [7:0] half_reg, guard_reg;

	rtc3w_pkg::out_item_t want_pins_q [$];
	rtc3w_pkg::out_item_t exp_pins;
	int mism_cnt = 0;
	int idle_cyc = 0;
	bit quiet = 1'b0;
	bit stall_req = 1'b0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic drive_bit(input logic [4:0] n);
		return (m_read && n >= rtc3w_pkg::CMD_CNT) ? 1'b1 : m_send[n[3:0]];
	endfunction

	function automatic rtc3w_pkg::out_item_t seq_tick(input rtc3w_pkg::in_item_t it);
		rtc3w_pkg::out_item_t r;
		logic req;
		logic [7:0] nxt, eh, eg;
		r = '0;
		req = (it.func == rtc3w_pkg::FUNC_WRITE) || (it.func == rtc3w_pkg::FUNC_READ);
		nxt = m_tick + 8'd1;
		eh = (half_reg == 8'd0) ? 8'd1 : half_reg;
		eg = (guard_reg == 8'd0) ? 8'd1 : guard_reg;
		if (m_phase == P_IDLE) begin
			if (req) begin
				m_read = (it.func == rtc3w_pkg::FUNC_READ);
				m_send = m_read ? {8'h00, it.command_byte | 8'h01}
					: {it.write_data, it.command_byte & 8'hFE};
				m_recv = 8'h00;
				m_bits = 5'd0;
				m_tick = 8'd0;
				m_en = 1'b1;
				m_clk = 1'b0;
				m_dat = 1'b1;
				m_phase = P_GUARD_ON;
			end
		end else begin
			r.rejected = req;
			case (m_phase)
				P_GUARD_ON: begin
					if (nxt >= eg) begin
						m_tick = 8'd0;
						m_bits = 5'd0;
						m_dat = drive_bit(5'd0);
						m_phase = P_LOW;
					end else begin
						m_tick = nxt;
					end
				end
				P_LOW: begin
					if (nxt >= eh) begin
						if (m_read && m_bits >= rtc3w_pkg::CMD_CNT && it.io_sample)
							m_recv[m_bits[2:0]] = 1'b1;
						m_tick = 8'd0;
						m_clk = 1'b1;
						m_phase = P_HIGH;
					end else begin
						m_tick = nxt;
					end
				end
				P_HIGH: begin
					if (nxt >= eh) begin
						m_tick = 8'd0;
						m_clk = 1'b0;
						m_bits = m_bits + 5'd1;
						if (m_bits >= rtc3w_pkg::TOTAL_CNT) begin
							m_en = 1'b0;
							m_dat = 1'b1;
							m_phase = P_GUARD_OFF;
						end else begin
							m_dat = drive_bit(m_bits);
							m_phase = P_LOW;
						end
					end else begin
						m_tick = nxt;
					end
				end
				P_GUARD_OFF: begin
					if (nxt >= eg) begin
						m_tick = 8'd0;
						if (m_read) begin
							r.read_done = 1'b1;
							r.read_byte = m_recv;
						end
						m_phase = P_IDLE;
					end else begin
						m_tick = nxt;
					end
				end
				default: ;
			endcase
		end
		r.enable_level = m_en;
		r.clock_level = m_clk;
		r.data_level = m_dat;
		r.busy_res = (m_phase != P_IDLE);
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
	endfunction

	// mostly complete transfers; some rejected requests and no-op funcs as noise
	function automatic rtc3w_pkg::in_item_t pick_item();
		rtc3w_pkg::in_item_t it;
		int r;
		it.command_byte = 8'($urandom);
		it.write_data = 8'($urandom);
		it.io_sample = 1'($urandom);
		r = $urandom_range(99);
		if (m_phase == P_IDLE) begin
			if (r < 80)
				it.func = $urandom_range(1) ? rtc3w_pkg::FUNC_READ : rtc3w_pkg::FUNC_WRITE;
			else
				it.func = (r < 90) ? rtc3w_pkg::FUNC_TICK : FUNC_NOP;
		end else begin
			if (r < 92)
				it.func = rtc3w_pkg::FUNC_TICK;
			else if (r < 95)
				it.func = FUNC_NOP;
			else
				it.func = $urandom_range(1) ? rtc3w_pkg::FUNC_READ : rtc3w_pkg::FUNC_WRITE;
		end
		return it;
	endfunction

	task automatic drive_item(input rtc3w_pkg::in_item_t it, input logic typed,
			input rtc3w_pkg::out_item_t want);
		int gap;
		rtc3w_pkg::out_item_t got;
		gap = (quiet || $urandom_range(3) != 0) ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		got = seq_tick(it);
		want_pins_q.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == rtc3w_pkg::CFG_HALF_PERIOD)
			half_reg = val;
		else if (idx == rtc3w_pkg::CFG_GUARD)
			guard_reg = val;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (want_pins_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic void cmp(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mism_cnt++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (want_pins_q.size() == 0) begin
				$error("result item with none expected");
				mism_cnt++;
			end else begin
				exp_pins = want_pins_q.pop_front();
				cmp("enable_level", 8'(exp_pins.enable_level), 8'(out_item.enable_level));
				cmp("clock_level", 8'(exp_pins.clock_level), 8'(out_item.clock_level));
				cmp("data_level", 8'(exp_pins.data_level), 8'(out_item.data_level));
				cmp("read_byte", exp_pins.read_byte, out_item.read_byte);
				cmp("read_done", 8'(exp_pins.read_done), 8'(out_item.read_done));
				cmp("busy_res", 8'(exp_pins.busy_res), 8'(out_item.busy_res));
				cmp("rejected", 8'(exp_pins.rejected), 8'(out_item.rejected));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	// result side back-pressure
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		while (!arst_n) @(negedge clk);
		forever begin
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
				stall_req = 1'b0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		logic [7:0] h, g;
		bit started;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_phase = P_IDLE;
		m_bits = '0;
		m_send = '0;
		m_recv = '0;
		m_tick = '0;
		m_read = 1'b0;
		m_en = 1'b0;
		m_clk = 1'b0;
		m_dat = 1'b1;
		half_reg = rtc3w_pkg::HALF_PERIOD_RST;
		guard_reg = rtc3w_pkg::GUARD_RST;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIR_ROWS[i])
			repeat (DIR_ROWS[i].reps)
				drive_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].want);

		for (int p = 0; p < NUM_SETS; p++) begin
			drain();
			h = HALF_SET[p];
			g = GUARD_SET[p];
			if (p == 5 || p == 6 || p == 9) begin
				h = 8'($urandom_range(1, 6));
				g = 8'($urandom_range(1, 8));
			end
			if (p[0]) begin
				write_reg(rtc3w_pkg::CFG_GUARD, g);
				write_reg(rtc3w_pkg::CFG_HALF_PERIOD, h);
			end else begin
				write_reg(rtc3w_pkg::CFG_HALF_PERIOD, h);
				write_reg(rtc3w_pkg::CFG_GUARD, g);
			end
			if (p == 3) begin
				write_reg(CFG_SPARE_LO, 8'($urandom));
				write_reg(CFG_SPARE_HI, 8'hFF);
			end
			cfg_valid <= 1'b0;
			quiet = (p % 3 == 1);
			if (int'(h == 0 ? 1 : h) * 32 + 2 * int'(g == 0 ? 1 : g) > 200) begin
				// slow setting: a single transfer
				started = 1'b0;
				while (!(started && m_phase == P_IDLE)) begin
					drive_item(pick_item(), 1'b0, OUT_IDLE);
					if (m_phase != P_IDLE)
						started = 1'b1;
				end
			end else begin
				for (n = 0; n < ITEMS_PER_SET; n++) begin
					if (p == 2 && n == 120)
						stall_req = 1'b1;
					drive_item(pick_item(), 1'b0, OUT_IDLE);
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mism_cnt == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
